### rtl/ajb_pkg.sv
// Shared types, constants and helper functions for the audio jitter buffer.
// Used by every module of the block except ajb_ram; depends on nothing.
package ajb_pkg;

    // Ring and batch control constants
    localparam int RING_DEPTH     = 8192;
    localparam int RING_FRAMES    = 48;
    localparam int PREROLL_FRAMES = 3;
    localparam int UNDERRUN_LIMIT = 2;

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(UNDERRUN_LIMIT + 2);
    localparam int FRAME_W = 8;
    localparam int FRAME_MAX = (1 << FRAME_W) - 1;

    localparam int CAP_RAW_W = $clog2(RING_FRAMES * FRAME_MAX + 1);
    localparam int CAP_W     = (CAP_RAW_W > PTR_W) ? CAP_RAW_W : PTR_W;
    localparam int PRE_RAW_W = $clog2(PREROLL_FRAMES * FRAME_MAX + 1);
    localparam int PRE_W     = (PRE_RAW_W > PTR_W) ? PRE_RAW_W : PTR_W;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int FILL_W   = 13;
    localparam int FILL_X_W = (PTR_W > FILL_W) ? PTR_W : FILL_W;
    localparam int FILL_MAX = (1 << FILL_W) - 1;
    localparam int VOL_W    = 8;

    // Register reset values
    localparam logic [FRAME_W-1:0] FRAME_RESET  = FRAME_W'(160);
    localparam logic [VOL_W-1:0]   VOLUME_RESET = VOL_W'(100);

    // Gain arithmetic: sample * percent / 100, divide by reciprocal multiply
    localparam int GAIN_MAX  = 200;
    localparam int GAIN_DIV  = 100;
    localparam int DIV_SHIFT = 30;
    localparam int DIV_RECIP = ((1 << DIV_SHIFT) + GAIN_DIV - 1) / GAIN_DIV;
    localparam int PROD_W    = SAMPLE_W + VOL_W + 1;
    localparam int MAG_W     = PROD_W - 1;
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
    localparam int QUOT_W    = MAG_W + RECIP_W;
    localparam int Q_W       = SAMPLE_W + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 1'b1;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_PULL  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_code_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic read_stage;
        logic mul_stage;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_pull;
    } dp_status_t;

    // Ring capacity in samples for a frame size
    function automatic logic [PTR_W-1:0] ring_cap(input logic [FRAME_W-1:0] frame);
        logic [FRAME_W-1:0] eff;
        logic [CAP_W-1:0]   full;
        eff  = (frame == '0) ? FRAME_W'(1) : frame;
        full = CAP_W'(RING_FRAMES) * CAP_W'(eff);
        if (full > CAP_W'(RING_DEPTH - 1))
            return PTR_W'(RING_DEPTH - 1);
        return PTR_W'(full);
    endfunction

    // Fill level that ends a resync
    function automatic logic [PRE_W-1:0] preroll_level(input logic [FRAME_W-1:0] frame);
        logic [FRAME_W-1:0] eff;
        eff = (frame == '0) ? FRAME_W'(1) : frame;
        return PRE_W'(PREROLL_FRAMES) * PRE_W'(eff);
    endfunction

endpackage

### rtl/ajb_in_if.sv
// Input channel of the jitter buffer: valid/ready with command payload.
// Depends on ajb_pkg for field widths.
interface ajb_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic signed [ajb_pkg::SAMPLE_W-1:0] sample_in;
    logic                         last_of_batch;

    modport source (output valid, output command, output sample_in,
                    output last_of_batch, input ready);
    modport sink   (input valid, input command, input sample_in,
                    input last_of_batch, output ready);
endinterface

### rtl/ajb_out_if.sv
// Output channel of the jitter buffer: valid/ready with pulled sample.
// Depends on ajb_pkg for field widths.
interface ajb_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ajb_pkg::SAMPLE_W-1:0] sample_out;
    logic                                from_buffer;
    logic                                resync_active;
    logic [ajb_pkg::FILL_W-1:0]          fill_level;

    modport source (output valid, output sample_out, output from_buffer,
                    output resync_active, output fill_level, input ready);
    modport sink   (input valid, input sample_out, input from_buffer,
                    input resync_active, input fill_level, output ready);
endinterface

### rtl/ajb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module ajb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ajb_ctrl.sv
// Controller of the jitter buffer: transaction acceptance and pull sequencing.
// Depends on ajb_pkg for the command and status structs.
module ajb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ajb_pkg::dp_status_t status,
    output ajb_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Decode commands from state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.is_pull)
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read_stage = 1'b1;
                state_next     = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_stage = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/ajb_dp.sv
// Datapath of the jitter buffer: ring pointers, batch flags, sample RAM, gain.
// Depends on ajb_pkg and instantiates ajb_ram.
module ajb_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ajb_pkg::ctrl_cmd_t                     cmd,
    output ajb_pkg::dp_status_t                    status,
    input  logic [1:0]                             command,
    input  logic signed [ajb_pkg::SAMPLE_W-1:0]    sample_in,
    input  logic                                   last_of_batch,
    input  logic                                   cfg_we,
    input  logic [ajb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ajb_pkg::FRAME_W-1:0]            cfg_wdata,
    output logic signed [ajb_pkg::SAMPLE_W-1:0]    sample_out,
    output logic                                   from_buffer,
    output logic                                   resync_active,
    output logic [ajb_pkg::FILL_W-1:0]             fill_level
);

    localparam int PTR_W = ajb_pkg::PTR_W;
    localparam int CNT_W = ajb_pkg::CNT_W;

    // Control state
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] fill_reg, fill_next;
    logic             resync_reg, resync_next;
    logic [CNT_W-1:0] under_reg, under_next;
    logic             short_reg, short_next;
    logic [PTR_W-1:0] cap_reg;
    logic [ajb_pkg::PRE_W-1:0] preroll_reg;
    logic [ajb_pkg::VOL_W-1:0] vol_reg;

    // Pull pipeline payload
    logic                                from_reg;
    logic                                resync_out_reg;
    logic [ajb_pkg::FILL_W-1:0]          fill_out_reg;
    logic signed [ajb_pkg::PROD_W-1:0]   prod_reg;
    logic                                neg_reg;
    logic [ajb_pkg::QUOT_W-1:0]          quot_reg;
    logic signed [ajb_pkg::SAMPLE_W-1:0] sample_out_reg;
    logic                                from_buffer_reg;
    logic                                resync_active_reg;
    logic [ajb_pkg::FILL_W-1:0]          fill_level_reg;

    logic                     ram_we;
    logic                     ram_re;
    logic [ajb_pkg::SAMPLE_W-1:0] ram_rdata;
    logic                     pull_take;
    logic                     cmd_push;
    logic                     cmd_pull;
    logic                     cmd_flush;
    logic                     short_eff;
    logic [CNT_W-1:0]         under_inc;
    logic [ajb_pkg::PRE_W-1:0] fill_cmp;
    logic [ajb_pkg::FILL_X_W-1:0] fill_wide;
    logic [ajb_pkg::VOL_W-1:0] gain;
    logic signed [ajb_pkg::SAMPLE_W-1:0] raw;
    logic signed [ajb_pkg::VOL_W:0]      gain_s;
    logic signed [ajb_pkg::PROD_W-1:0]   prod_next;
    logic [ajb_pkg::PROD_W-1:0]          prod_abs;
    logic [ajb_pkg::MAG_W-1:0]           mag;
    logic [ajb_pkg::Q_W-1:0]             quot;
    logic [ajb_pkg::Q_W-1:0]             quot_neg;
    logic signed [ajb_pkg::SAMPLE_W-1:0] sat_sample;

    assign cmd_push  = (command == ajb_pkg::CMD_PUSH);
    assign cmd_pull  = (command == ajb_pkg::CMD_PULL);
    assign cmd_flush = (command == ajb_pkg::CMD_FLUSH);
    assign status.is_pull = cmd_pull;

    // Advance a ring pointer with wrap at the capacity
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] cap);
        logic [PTR_W:0] inc;
        inc = {1'b0, p} + (PTR_W+1)'(1);
        return (inc >= {1'b0, cap}) ? '0 : inc[PTR_W-1:0];
    endfunction

    assign pull_take = cmd.accept && cmd_pull && !resync_reg && (fill_reg != '0);
    assign ram_we    = cmd.accept && cmd_push && (fill_reg < cap_reg);
    assign ram_re    = pull_take;
    assign short_eff = short_reg || (fill_reg == '0);
    assign under_inc = (under_reg <= CNT_W'(ajb_pkg::UNDERRUN_LIMIT))
                       ? under_reg + CNT_W'(1) : under_reg;

    // Next control state for an accepted transaction
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        resync_next = resync_reg;
        under_next  = under_reg;
        short_next  = short_reg;
        fill_cmp    = '0;
        if (cmd.accept)
        begin
            if (cmd_push)
            begin
                if (ram_we)
                begin
                    wr_ptr_next = advance(wr_ptr_reg, cap_reg);
                    fill_next   = fill_reg + PTR_W'(1);
                end
                fill_cmp = ajb_pkg::PRE_W'(fill_next);
                if (last_of_batch && resync_reg && (fill_cmp >= preroll_reg))
                begin
                    resync_next = 1'b0;
                    under_next  = '0;
                end
            end
            else if (cmd_flush)
            begin
                wr_ptr_next = '0;
                rd_ptr_next = '0;
                fill_next   = '0;
            end
            else if (cmd_pull)
            begin
                if (!resync_reg)
                begin
                    if (pull_take)
                    begin
                        rd_ptr_next = advance(rd_ptr_reg, cap_reg);
                        fill_next   = fill_reg - PTR_W'(1);
                    end
                    else
                    begin
                        short_next = 1'b1;
                    end
                    if (last_of_batch)
                    begin
                        if (short_eff)
                        begin
                            under_next = under_inc;
                            if (under_inc > CNT_W'(ajb_pkg::UNDERRUN_LIMIT))
                            begin
                                resync_next = 1'b1;
                                wr_ptr_next = '0;
                                rd_ptr_next = '0;
                                fill_next   = '0;
                            end
                        end
                        else
                        begin
                            under_next = '0;
                        end
                    end
                end
                if (last_of_batch)
                    short_next = 1'b0;
            end
        end
    end

    // Control registers and configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            resync_reg  <= 1'b0;
            under_reg   <= '0;
            short_reg   <= 1'b0;
            cap_reg     <= ajb_pkg::ring_cap(ajb_pkg::FRAME_RESET);
            preroll_reg <= ajb_pkg::preroll_level(ajb_pkg::FRAME_RESET);
            vol_reg     <= ajb_pkg::VOLUME_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ajb_pkg::REG_FRAME:
                begin
                    cap_reg     <= ajb_pkg::ring_cap(cfg_wdata);
                    preroll_reg <= ajb_pkg::preroll_level(cfg_wdata);
                    wr_ptr_reg  <= '0;
                    rd_ptr_reg  <= '0;
                    fill_reg    <= '0;
                    resync_reg  <= 1'b0;
                    under_reg   <= '0;
                    short_reg   <= 1'b0;
                end
                default:
                begin
                    vol_reg <= cfg_wdata;
                end
            endcase
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            resync_reg <= resync_next;
            under_reg  <= under_next;
            short_reg  <= short_next;
        end
    end

    // Sample ring storage
    ajb_ram #(
        .WIDTH (ajb_pkg::SAMPLE_W),
        .DEPTH (ajb_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (sample_in),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Saturate the fill level to the field range
    assign fill_wide = ajb_pkg::FILL_X_W'(fill_next);

    // Capture pull result flags at acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.accept && cmd_pull)
        begin
            from_reg       <= pull_take;
            resync_out_reg <= resync_next;
            fill_out_reg   <= (fill_wide > ajb_pkg::FILL_X_W'(ajb_pkg::FILL_MAX))
                              ? ajb_pkg::FILL_W'(ajb_pkg::FILL_MAX)
                              : fill_wide[ajb_pkg::FILL_W-1:0];
        end
    end

    // Gain stage: sample times clamped percent
    assign gain      = (vol_reg > ajb_pkg::VOL_W'(ajb_pkg::GAIN_MAX))
                       ? ajb_pkg::VOL_W'(ajb_pkg::GAIN_MAX) : vol_reg;
    assign raw       = from_reg ? $signed(ram_rdata) : '0;
    assign gain_s    = $signed({1'b0, gain});
    assign prod_next = raw * gain_s;

    // Divide stage: magnitude times reciprocal of the percent base
    assign prod_abs = prod_reg[ajb_pkg::PROD_W-1] ? ajb_pkg::PROD_W'(-prod_reg)
                                                  : ajb_pkg::PROD_W'(prod_reg);
    assign mag      = prod_abs[ajb_pkg::MAG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.read_stage)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mul_stage)
        begin
            neg_reg  <= prod_reg[ajb_pkg::PROD_W-1];
            quot_reg <= ajb_pkg::QUOT_W'(mag) *
                        ajb_pkg::QUOT_W'(ajb_pkg::DIV_RECIP);
        end
    end

    // Restore sign and saturate to the sample range
    assign quot     = quot_reg[ajb_pkg::DIV_SHIFT +: ajb_pkg::Q_W];
    assign quot_neg = -quot;
    always_comb
    begin
        if (neg_reg)
        begin
            if (quot > ajb_pkg::Q_W'(32768))
                sat_sample = 16'sh8000;
            else
                sat_sample = $signed(quot_neg[ajb_pkg::SAMPLE_W-1:0]);
        end
        else
        begin
            if (quot > ajb_pkg::Q_W'(32767))
                sat_sample = 16'sh7fff;
            else
                sat_sample = $signed(quot[ajb_pkg::SAMPLE_W-1:0]);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sample_out_reg    <= sat_sample;
            from_buffer_reg   <= from_reg;
            resync_active_reg <= resync_out_reg;
            fill_level_reg    <= fill_out_reg;
        end
    end

    assign sample_out    = sample_out_reg;
    assign from_buffer   = from_buffer_reg;
    assign resync_active = resync_active_reg;
    assign fill_level    = fill_level_reg;

endmodule

### rtl/audio_jitter_buffer_with_gain.sv
// Top level of the audio jitter buffer with output gain.
// Depends on ajb_pkg, ajb_in_if, ajb_out_if, ajb_ctrl, ajb_dp and ajb_ram.
//
// Usage:
//   The input channel carries commands: push a sample, pull a sample or
//   flush the ring. Only a pull produces a transaction on the output
//   channel: the gained sample, whether it came from the ring, the resync
//   state and the fill level after the pull.
//   The configuration port writes the frame size in samples (index 0) and
//   the volume in percent (index 1); write only while the block is idle. A
//   frame size write empties the ring and clears resync state.
// Timing:
//   Push and flush complete at acceptance, so back-to-back pushes run at one
//   per cycle while no pull is in flight. A pull steps through ring read,
//   multiply by the gain, multiply by the reciprocal of 100 and output load;
//   the next transaction is taken only after the output load. A finished
//   result waits in the output register while new pushes are taken; a
//   following pull stalls in its last step until the receiver takes the
//   waiting result.
// Reset:
//   Pointers, fill and batch flags clear at once; no clearing pass over the
//   ring is needed, since the fill count tracks which entries hold data.
module audio_jitter_buffer_with_gain (
    input  logic                                clk,
    input  logic                                rst_n,
    ajb_in_if.sink                              in,
    ajb_out_if.source                           out,
    input  logic                                cfg_we,
    input  logic [ajb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ajb_pkg::FRAME_W-1:0]         cfg_wdata
);

    ajb_pkg::ctrl_cmd_t  cmd;
    ajb_pkg::dp_status_t status;

    // Sequencer
    ajb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Ring, flags and gain
    ajb_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .command       (in.command),
        .sample_in     (in.sample_in),
        .last_of_batch (in.last_of_batch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .sample_out    (out.sample_out),
        .from_buffer   (out.from_buffer),
        .resync_active (out.resync_active),
        .fill_level    (out.fill_level)
    );

    // An accepted pull blocks new transactions while it is in flight
    a_pull_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && in.valid && status.is_pull) |=> !in.ready)
        else $error("input accepted during a pull in flight");

    // A loaded result is presented on the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out.valid)
        else $error("loaded result not presented");

    // Padding is silent
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.from_buffer) |-> (out.sample_out == '0))
        else $error("padded sample is not zero");

    // No transaction is accepted in the last step of an accepted pull
    a_pull_span: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && in.valid && status.is_pull) |-> ##3 !cmd.accept)
        else $error("pull sequence cut short");

endmodule
